FILE: design/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared definitions for the strip detector depth calibration block
// Geometry constants, derived widths, the front-to-back job word and the
// result word.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int DETECTORS          = 12;
  localparam int STRIPS             = 37;
  localparam int MAX_STRIPS_PER_HIT = 8;

  localparam int TIMING_MAX    = 36;
  localparam int CTD_SCALE     = 10;
  localparam int SPAN_UM       = 14000;
  localparam int FACE_UM       = 500;
  localparam int LOW_LIMIT_UM  = -500;
  localparam int HIGH_LIMIT_UM = 15500;
  localparam int THICK_UM      = 15000;
  localparam int MID_UM        = 7500;
  localparam int PITCH_UM      = 2000;
  localparam int CENTER_STRIP  = (STRIPS + 1) / 2;

  localparam int CALIB_DEPTH = DETECTORS * STRIPS * STRIPS;
  localparam int IDX_W       = $clog2(CALIB_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 20;
  localparam int DIV_C_W = $clog2(DIV_N_W);

  localparam int IN_W  = 64;
  localparam int OUT_W = 96;

  typedef enum logic [1:0] {
    ST_SINGLE = 2'd0,
    ST_SHARED = 2'd1,
    ST_LLD    = 2'd2,
    ST_UNCAL  = 2'd3
  } status_t;

  // One queue entry: either a table write or a classified hit.
  typedef struct packed {
    logic               is_write;
    status_t            status;
    logic [3:0]         det;
    logic [IDX_W-1:0]   idx;
    logic [5:0]         xs;
    logic [5:0]         ys;
    logic [7:0]         xt;
    logic [7:0]         yt;
    logic signed [3:0]  dither;
    logic [1:0]         field;
    logic [15:0]        value;
  } job_t;

  typedef struct packed {
    logic        [15:0] depth_fwhm;
    logic signed [16:0] y_center;
    logic signed [16:0] x_center;
    logic signed [15:0] z_center;
    logic signed [15:0] depth_front;
    logic        [3:0]  hit_detector;
    logic               out_of_range;
    status_t            status;
  } result_t;

endpackage

FILE: design/sdc_front.sv
// ----------------------------------------------------------------------------
// sdc_front: strip collection and hit classification
// Accumulates strips of a hit, classifies the hit when its last strip is in
// and queues a job; table writes are range checked and queued in order.
// ----------------------------------------------------------------------------
module sdc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [sdc_pkg::IN_W-1:0] s_tdata,
  input  logic                  s_tlast,
  input  logic                  s_tuser,
  input  logic                  queue_full,
  output logic                  push_valid,
  output sdc_pkg::job_t         push_job
);
  import sdc_pkg::*;

  typedef struct packed {
    logic        seen;
    logic [5:0]  strip;
    logic [7:0]  timing;
    logic [15:0] energy;
  } strip_rec_t;

  function automatic logic timing_ok(input logic [7:0] t);
    return (t >= 8'd1) && (t <= 8'(TIMING_MAX));
  endfunction

  function automatic logic strip_ok(input logic [5:0] s);
    return (s >= 6'd1) && (s <= 6'(STRIPS));
  endfunction

  function automatic logic adjacent(input logic [5:0] a, input logic [5:0] b);
    return ({1'b0, a} == {1'b0, b} + 7'd1) || ({1'b0, b} == {1'b0, a} + 7'd1);
  endfunction

  function automatic logic [IDX_W-1:0] calc_idx(input logic [3:0] d,
                                                input logic [5:0] a,
                                                input logic [5:0] b);
    logic [31:0] t;
    t = (32'(d) * 32'(STRIPS) + 32'(a) - 32'd1) * 32'(STRIPS) + 32'(b) - 32'd1;
    return t[IDX_W-1:0];
  endfunction

  // Input word fields.
  logic [3:0]        in_det;
  logic              in_xside;
  logic [5:0]        in_strip;
  logic [5:0]        in_other;
  logic [7:0]        in_timing;
  logic [15:0]       in_energy;
  logic signed [3:0] in_dither;
  logic [1:0]        in_field;
  logic [15:0]       in_value;

  assign in_det    = s_tdata[3:0];
  assign in_xside  = s_tdata[4];
  assign in_strip  = s_tdata[10:5];
  assign in_other  = s_tdata[16:11];
  assign in_timing = s_tdata[24:17];
  assign in_energy = s_tdata[40:25];
  assign in_dither = s_tdata[44:41];
  assign in_field  = s_tdata[46:45];
  assign in_value  = s_tdata[62:47];

  logic [3:0]        x_count, y_count;
  strip_rec_t        first_x, first_y, best_x, best_y;
  logic [5:0]        x_pair0, x_pair1, y_pair0, y_pair1;
  logic [3:0]        hit_det;
  logic              pending;
  logic signed [3:0] dither_reg;

  logic accept, wr_ok, hit_push;

  assign s_tready = !pending && !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign wr_ok    = (in_det < 4'(DETECTORS)) && strip_ok(in_strip) && strip_ok(in_other);
  assign hit_push = pending && !queue_full;

  // Per-side update of a strip that is being added.
  logic [3:0] cnt_cur, cnt_next;
  logic [5:0] p0_next, p1_next, p0_cur, p1_cur;
  strip_rec_t first_cur, best_cur, first_next, best_next;

  always_comb begin
    cnt_cur   = in_xside ? x_count : y_count;
    p0_cur    = in_xside ? x_pair0 : y_pair0;
    p1_cur    = in_xside ? x_pair1 : y_pair1;
    first_cur = in_xside ? first_x : first_y;
    best_cur  = in_xside ? best_x : best_y;
    cnt_next  = cnt_cur;
    p0_next   = p0_cur;
    p1_next   = p1_cur;
    if (cnt_cur < 4'(MAX_STRIPS_PER_HIT)) begin
      if (cnt_cur == 4'd0) p0_next = in_strip;
      else if (cnt_cur == 4'd1) p1_next = in_strip;
      cnt_next = cnt_cur + 4'd1;
    end
    first_next = first_cur;
    if (!first_cur.seen || !timing_ok(first_cur.timing)) begin
      first_next = '{seen: 1'b1, strip: in_strip, timing: in_timing, energy: in_energy};
    end
    best_next = best_cur;
    if (timing_ok(in_timing) && (!best_cur.seen || in_energy > best_cur.energy)) begin
      best_next = '{seen: 1'b1, strip: in_strip, timing: in_timing, energy: in_energy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= '0;
      y_count <= '0;
      first_x <= '0;
      first_y <= '0;
      best_x  <= '0;
      best_y  <= '0;
      x_pair0 <= '0;
      x_pair1 <= '0;
      y_pair0 <= '0;
      y_pair1 <= '0;
      hit_det <= '0;
      pending <= 1'b0;
    end else if (hit_push) begin
      pending <= 1'b0;
      x_count <= '0;
      y_count <= '0;
      first_x <= '0;
      first_y <= '0;
      best_x  <= '0;
      best_y  <= '0;
      x_pair0 <= '0;
      x_pair1 <= '0;
      y_pair0 <= '0;
      y_pair1 <= '0;
    end else if (accept && !s_tuser) begin
      hit_det <= in_det;
      if (in_xside) begin
        x_count <= cnt_next;
        x_pair0 <= p0_next;
        x_pair1 <= p1_next;
        first_x <= first_next;
        best_x  <= best_next;
      end else begin
        y_count <= cnt_next;
        y_pair0 <= p0_next;
        y_pair1 <= p1_next;
        first_y <= first_next;
        best_y  <= best_next;
      end
      if (s_tlast) pending <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !s_tuser && s_tlast) dither_reg <= in_dither;
  end

  // Classification of the finished hit.
  status_t    cls;
  logic [5:0] cxs, cys;
  logic [7:0] cxt, cyt;

  always_comb begin
    cls = ST_UNCAL;
    cxs = '0;
    cys = '0;
    cxt = '0;
    cyt = '0;
    if (hit_det >= 4'(DETECTORS) || !first_x.seen || !first_y.seen) begin
      cls = ST_UNCAL;
    end else if (!timing_ok(first_x.timing) || !timing_ok(first_y.timing)) begin
      if (x_count == 4'd1 && y_count == 4'd1) begin
        cls = ST_LLD;
        cxs = first_x.strip;
        cxt = first_x.timing;
        cys = first_y.strip;
        cyt = first_y.timing;
      end
    end else if (!strip_ok(first_x.strip) || !strip_ok(first_y.strip)) begin
      cls = ST_UNCAL;
    end else if (x_count == 4'd1 && y_count == 4'd1) begin
      cls = ST_SINGLE;
      cxs = first_x.strip;
      cxt = first_x.timing;
      cys = first_y.strip;
      cyt = first_y.timing;
    end else if (x_count >= 4'd1 && x_count <= 4'd2 && y_count >= 4'd1 && y_count <= 4'd2
                 && (x_count == 4'd1 || adjacent(x_pair0, x_pair1))
                 && (y_count == 4'd1 || adjacent(y_pair0, y_pair1))) begin
      cls = ST_SHARED;
      cxs = best_x.strip;
      cxt = best_x.timing;
      cys = best_y.strip;
      cyt = best_y.timing;
    end
    if (cls != ST_UNCAL && (!strip_ok(cxs) || !strip_ok(cys))) cls = ST_UNCAL;
  end

  always_comb begin
    push_job = '0;
    if (pending) begin
      push_job.is_write = 1'b0;
      push_job.status   = cls;
      push_job.det      = hit_det;
      push_job.idx      = calc_idx(hit_det, cxs, cys);
      push_job.xs       = cxs;
      push_job.ys       = cys;
      push_job.xt       = cxt;
      push_job.yt       = cyt;
      push_job.dither   = dither_reg;
    end else begin
      push_job.is_write = 1'b1;
      push_job.status   = ST_UNCAL;
      push_job.det      = in_det;
      push_job.idx      = calc_idx(in_det, in_strip, in_other);
      push_job.field    = in_field;
      push_job.value    = in_value;
    end
  end

  assign push_valid = hit_push || (accept && s_tuser && wr_ok);

endmodule

FILE: design/sdc_queue.sv
// ----------------------------------------------------------------------------
// sdc_queue: short job queue between front and back
// A few entries of registers with head and tail pointers.
// ----------------------------------------------------------------------------
module sdc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sdc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sdc_pkg::job_t head_job
);
  import sdc_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

FILE: design/sdc_back.sv
// ----------------------------------------------------------------------------
// sdc_back: calibration table and depth computation
// Holds the per-pixel table, looks up the pixel of a hit, runs two rounded
// divisions through one shared radix-2 divider and registers the result.
// ----------------------------------------------------------------------------
module sdc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  sdc_pkg::job_t            head_job,
  output logic                     pop,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [sdc_pkg::OUT_W-1:0] m_tdata
);
  import sdc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,
    S_SETZ = 6'b000100,
    S_DIVZ = 6'b001000,
    S_SETF = 6'b010000,
    S_DIVF = 6'b100000
  } state_t;

  // Result word of a hit that cannot be calibrated: only its status and detector are set.
  function automatic result_t uncal_word(input logic [3:0] d);
    result_t r;
    r              = '0;
    r.status       = ST_UNCAL;
    r.hit_detector = d;
    return r;
  endfunction

  state_t state;
  logic   fin;
  logic   res_set;

  // Calibration table, one array per field so a hit reads all four at once.
  logic [15:0] mem_front [CALIB_DEPTH];
  logic [15:0] mem_back  [CALIB_DEPTH];
  logic [15:0] mem_ffront[CALIB_DEPTH];
  logic [15:0] mem_fback [CALIB_DEPTH];
  logic signed [15:0] rd_f, rd_b, rd_ff, rd_fb;

  job_t              job;
  result_t           res;
  logic              res_valid;
  logic signed [16:0] span;
  logic signed [32:0] nz, nf;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_rem, div_den;
  logic [DIV_C_W-1:0] div_cnt;
  logic               div_neg;
  logic signed [33:0] zq;

  logic do_write, do_read;

  assign pop = (state == S_IDLE) && !fin && head_valid && (head_job.is_write || !res_valid);
  assign do_write = pop && head_job.is_write;
  assign do_read  = pop && !head_job.is_write && head_job.status != ST_UNCAL;

  always_ff @(posedge clk) begin
    if (do_write) begin
      if (head_job.field == 2'd0) mem_front[head_job.idx]  <= head_job.value;
      if (head_job.field == 2'd1) mem_back[head_job.idx]   <= head_job.value;
      if (head_job.field == 2'd2) mem_ffront[head_job.idx] <= head_job.value;
      if (head_job.field == 2'd3) mem_fback[head_job.idx]  <= head_job.value;
    end
    if (do_read) begin
      rd_f  <= mem_front[head_job.idx];
      rd_b  <= mem_back[head_job.idx];
      rd_ff <= mem_ffront[head_job.idx];
      rd_fb <= mem_fback[head_job.idx];
    end
  end

  // Time difference in Q14.4 and the two numerators.
  logic signed [8:0]  tdiff;
  logic signed [13:0] tscaled;
  logic signed [17:0] ctd;
  logic signed [18:0] ctd_rel;
  logic signed [16:0] span_c;
  logic signed [16:0] fw_sum;

  always_comb begin
    tdiff   = $signed({1'b0, job.xt}) - $signed({1'b0, job.yt});
    tscaled = 14'(tdiff * $signed(14'(CTD_SCALE))) + 14'(job.dither);
    ctd     = 18'(tscaled) <<< 4;
    ctd_rel = 19'(ctd) - 19'(rd_f);
    span_c  = 17'(rd_b) - 17'(rd_f);
    fw_sum  = 17'(rd_ff) + 17'(rd_fb);
  end

  // Divider step: restoring, one quotient bit per cycle.
  logic [DIV_D_W:0]   rem_sh, rem_sub;
  logic               q_bit;
  logic [DIV_N_W-1:0] quo_next;

  always_comb begin
    rem_sh   = {div_rem, div_num[DIV_N_W-1]};
    rem_sub  = rem_sh - {1'b0, div_den};
    q_bit    = (rem_sh >= {1'b0, div_den});
    quo_next = {div_num[DIV_N_W-2:0], q_bit};
  end

  // Operand setup for a rounded division: N = 2|n| + |d|, D = 2|d|.
  logic [32:0]        abs_nz, abs_nf;
  logic [16:0]        abs_span;
  logic [DIV_N_W-1:0] nz_num, nf_num;
  logic [DIV_D_W-1:0] nz_den, nf_den;

  always_comb begin
    abs_nz   = nz[32] ? 33'(-nz) : 33'(nz);
    abs_nf   = nf[32] ? 33'(-nf) : 33'(nf);
    abs_span = span[16] ? 17'(-span) : 17'(span);
    nz_num   = {abs_nz[DIV_N_W-2:0], 1'b0} + DIV_N_W'(abs_span);
    nz_den   = DIV_D_W'({abs_span, 1'b0});
    nf_num   = {abs_nf[DIV_N_W-2:0], 1'b0} + DIV_N_W'({abs_span, 1'b0});
    nf_den   = DIV_D_W'({abs_span, 2'b00});
  end

  // Final formatting of a calibrated hit.
  logic signed [33:0] q_signed, fw_val, z_clamped;
  logic signed [34:0] zc_val;
  logic signed [7:0]  xdiff, ydiff;
  result_t            res_calc;

  always_comb begin
    q_signed = $signed({2'b00, div_num});
    fw_val   = div_neg ? -q_signed : q_signed;
    z_clamped = zq;
    if (zq < 34'sd0 && zq > 34'(LOW_LIMIT_UM)) z_clamped = '0;
    if (zq > 34'(THICK_UM) && zq < 34'(HIGH_LIMIT_UM)) z_clamped = 34'(THICK_UM);
    zc_val = 35'(MID_UM) - 35'(z_clamped);
    xdiff  = 8'(CENTER_STRIP) - $signed({2'b00, job.xs});
    ydiff  = 8'(CENTER_STRIP) - $signed({2'b00, job.ys});
    res_calc = '0;
    res_calc.status       = job.status;
    res_calc.hit_detector = job.det;
    res_calc.out_of_range = (job.status != ST_LLD)
                            && (zq < 34'(LOW_LIMIT_UM) || zq > 34'(HIGH_LIMIT_UM));
    if (z_clamped > 34'sd32767)       res_calc.depth_front = 16'sh7fff;
    else if (z_clamped < -34'sd32768) res_calc.depth_front = 16'sh8000;
    else                              res_calc.depth_front = z_clamped[15:0];
    if (zc_val > 35'sd32767)          res_calc.z_center = 16'sh7fff;
    else if (zc_val < -35'sd32768)    res_calc.z_center = 16'sh8000;
    else                              res_calc.z_center = zc_val[15:0];
    res_calc.x_center = 17'(ydiff * $signed(17'(PITCH_UM)));
    res_calc.y_center = 17'(xdiff * $signed(17'(PITCH_UM)));
    if (fw_val < 34'sd0)              res_calc.depth_fwhm = '0;
    else if (fw_val > 34'sd65535)     res_calc.depth_fwhm = 16'hffff;
    else                              res_calc.depth_fwhm = fw_val[15:0];
  end

  // The result register fills when a division pair ends, when an
  // uncalibratable hit is taken or when the looked-up span is zero.
  assign res_set = fin || (pop && !head_job.is_write && head_job.status == ST_UNCAL)
                   || (state == S_CALC && span_c == 17'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      fin       <= 1'b0;
    end else begin
      fin <= (state == S_DIVF) && (div_cnt == DIV_C_W'(DIV_N_W - 1));
      if (res_set) res_valid <= 1'b1;
      else if (res_valid && m_tready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop && !head_job.is_write && head_job.status != ST_UNCAL) state <= S_CALC;
        end
        S_CALC: begin
          if (span_c == 17'sd0) begin
            state <= S_IDLE;
          end else begin
            state <= S_SETZ;
          end
        end
        S_SETZ: begin
          state <= S_DIVZ;
        end
        S_DIVZ: begin
          if (div_cnt == DIV_C_W'(DIV_N_W - 1)) state <= S_SETF;
        end
        S_SETF: begin
          state <= S_DIVF;
        end
        S_DIVF: begin
          if (div_cnt == DIV_C_W'(DIV_N_W - 1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (fin) begin
          res <= res_calc;
        end else if (pop && !head_job.is_write) begin
          job <= head_job;
          res <= uncal_word(head_job.det);
        end
      end
      S_CALC: begin
        span <= span_c;
        nz   <= 33'(ctd_rel) * 33'(SPAN_UM);
        nf   <= 33'(fw_sum) * 33'(SPAN_UM);
        if (span_c == 17'sd0) res <= uncal_word(job.det);
      end
      S_SETZ: begin
        div_num <= nz_num;
        div_den <= nz_den;
        div_rem <= '0;
        div_cnt <= '0;
        div_neg <= nz[32] ^ span[16];
      end
      S_SETF: begin
        zq      <= (div_neg ? -q_signed : q_signed) + 34'(FACE_UM);
        div_num <= nf_num;
        div_den <= nf_den;
        div_rem <= '0;
        div_cnt <= '0;
        div_neg <= nf[32] ^ span[16];
      end
      S_DIVZ, S_DIVF: begin
        div_num <= quo_next;
        div_rem <= q_bit ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        div_cnt <= div_cnt + DIV_C_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {(OUT_W - $bits(result_t))'(0), res};

endmodule

FILE: design/strip_detector_depth_calibration.sv
// ----------------------------------------------------------------------------
// strip_detector_depth_calibration: per-pixel linear depth calibration
// Collects strip words into hits, classifies each hit and turns the
// cathode-anode time difference into depth through a calibration table.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                      End of item
//  s_*      in   strip word or table write (tuser=1)          tlast on last strip
//  m_*      out  one result word per finished hit             -
//
// The word that ends a hit holds the input while the hit is classified and
// queued. Table writes pass through the same queue, so they apply in arrival
// order. In the back part, a calibrated hit goes from queue to result through
// table read, product stage and two passes of the shared radix-2 divider.
// An uncalibratable hit fills the result register as soon as it is taken from
// the queue.
// Reset is synchronous; the calibration table is not cleared and must be
// written before use. The queue lets input keep flowing while a result waits.
//
module strip_detector_depth_calibration (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: detector[4], is_x_side[1], strip_id[6], other_strip_id[6],
  // timing[8], energy[16], dither[4], table_field[2], table_value[16], zero pad
  input  logic [sdc_pkg::IN_W-1:0] s_tdata,
  input  logic        s_tlast,   // end_of_hit
  input  logic        s_tuser,   // kind: 0 strip, 1 table write
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: status[2], out_of_range[1], hit_detector[4],
  // depth_front[16], z_center[16], x_center[17], y_center[17], depth_fwhm[16]
  output logic [sdc_pkg::OUT_W-1:0] m_tdata
);
  import sdc_pkg::*;

  logic push_valid, queue_full, pop, head_valid;
  job_t push_job, head_job;

  // Front: strip accumulation and classification.
  sdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // Job queue decoupling the two halves.
  sdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: table, division and result register.
  sdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: design/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker: port-level checks for the depth calibration block
// Watches the result channel for stalls and status-dependent field rules.
// ----------------------------------------------------------------------------
module sdc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [sdc_pkg::OUT_W-1:0] m_tdata
);
  import sdc_pkg::*;

  // A stalled result word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // An uncalibratable hit carries only its detector.
  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_UNCAL |-> m_tdata[2] == 1'b0 && m_tdata[88:7] == '0)
    else $error("uncalibratable result has nonzero fields");

  // Low-level-discriminator hits are never flagged out of range.
  a_lld_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_LLD |-> m_tdata[2] == 1'b0)
    else $error("LLD result flagged out of range");

  // Calibrated hits come from a detector that exists.
  a_det_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_UNCAL |-> m_tdata[6:3] < 4'(DETECTORS))
    else $error("calibrated result with bad detector");

endmodule

bind strip_detector_depth_calibration sdc_checker u_sdc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/strip_detector_depth_calibration_tb.sv
// ----------------------------------------------------------------------------
// strip_detector_depth_calibration_tb: self-checking bench for depth calibration
// Loads calibration entries for a window of pixels, then streams directed and
// random strip hits with table writes mixed in. A scoreboard predicts each
// result word and checks it field by field against the master side.
// ----------------------------------------------------------------------------
module strip_detector_depth_calibration_tb;
  import sdc_pkg::*;

  // One input word, unpacked into its fields.
  typedef struct {
    logic              kind;
    logic [3:0]        det;
    logic              x_side;
    logic [5:0]        strip;
    logic [5:0]        other;
    logic [7:0]        timing;
    logic [15:0]       energy;
    logic              eoh;
    logic signed [3:0] dither;
    logic [1:0]        field;
    logic [15:0]       value;
  } word_t;

  localparam logic KIND_STRIP = 1'b0;
  localparam logic KIND_WRITE = 1'b1;
  localparam logic [1:0] FLD_FRONT_CTD  = 2'd0;
  localparam logic [1:0] FLD_BACK_CTD   = 2'd1;
  localparam logic [1:0] FLD_FRONT_FWHM = 2'd2;
  localparam logic [1:0] FLD_BACK_FWHM  = 2'd3;

  // Pixels that are calibrated up front. Hits on a real detector only use
  // these strips or strips outside 1..STRIPS, so no unwritten entry is read.
  int win_strip[6] = '{1, 2, 19, 20, 36, 37};
  int win_det[3]   = '{0, 5, 11};

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the table and hit state, queue of predicted words.
  // --------------------------------------------------------------------------
  class depth_scoreboard;
    logic [63:0] calib [CALIB_DEPTH];
    int          cnt [2], pair_lo [2], pair_hi [2];
    bit          first_seen [2], best_seen [2];
    int          first_strip [2], first_tim [2];
    int          best_strip [2], best_tim [2], best_en [2];
    int          hit_det;
    result_t     pending [$];
    int          errors;

    function new();
      errors  = 0;
      hit_det = 0;
      clear_hit();
    endfunction

    function void clear_hit();
      for (int s = 0; s < 2; s++) begin
        cnt[s] = 0; pair_lo[s] = 0; pair_hi[s] = 0;
        first_seen[s] = 0; first_strip[s] = 0; first_tim[s] = 0;
        best_seen[s] = 0; best_strip[s] = 0; best_tim[s] = 0; best_en[s] = 0;
      end
    endfunction

    function bit tim_ok(int t);
      return t >= 1 && t <= TIMING_MAX;
    endfunction

    function bit strip_ok(int s);
      return s >= 1 && s <= STRIPS;
    endfunction

    function bit adj(int side);
      return pair_lo[side] == pair_hi[side] + 1 || pair_hi[side] == pair_lo[side] + 1;
    endfunction

    // Rounded division, ties away from zero.
    function longint rdiv(longint n, longint d);
      bit     neg;
      longint an, ad, q;
      neg = (n < 0) != (d < 0);
      an  = n < 0 ? -n : n;
      ad  = d < 0 ? -d : d;
      q   = (2 * an + ad) / (2 * ad);
      return neg ? -q : q;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_word(word_t w);
      int side;
      if (w.kind == KIND_WRITE) begin
        if (w.det < DETECTORS && strip_ok(w.strip) && strip_ok(w.other))
          calib[(w.det * STRIPS + (w.strip - 1)) * STRIPS + (w.other - 1)][16*w.field +: 16]
            = w.value;
        return;
      end
      hit_det = w.det;
      side = w.x_side;
      if (cnt[side] < MAX_STRIPS_PER_HIT) begin
        if (cnt[side] == 0) pair_lo[side] = w.strip;
        else if (cnt[side] == 1) pair_hi[side] = w.strip;
        cnt[side]++;
      end
      if (!first_seen[side] || !tim_ok(first_tim[side])) begin
        first_seen[side] = 1; first_strip[side] = w.strip; first_tim[side] = w.timing;
      end
      if (tim_ok(w.timing) && (!best_seen[side] || w.energy > best_en[side])) begin
        best_seen[side] = 1; best_strip[side] = w.strip;
        best_tim[side] = w.timing; best_en[side] = w.energy;
      end
      if (!w.eoh) return;
      pending = {pending, predict_hit(w.dither)};
      clear_hit();
    endfunction

    // Classifies the collected hit and works out the calibrated result word.
    function result_t predict_hit(logic signed [3:0] dither);
      result_t     r;
      status_t     st;
      int          xs, ys, xt, yt;
      logic [63:0] e;
      longint      f, b, ff, fb, span, ctd, z, fw;
      st = ST_UNCAL; xs = 0; ys = 0; xt = 0; yt = 0;
      r  = '0;
      if (hit_det >= DETECTORS || !first_seen[1] || !first_seen[0]) begin
        st = ST_UNCAL;
      end else if (!tim_ok(first_tim[1]) || !tim_ok(first_tim[0])) begin
        // Low-level discriminator case: only a plain one-by-one hit is computed.
        if (cnt[1] == 1 && cnt[0] == 1) begin
          st = ST_LLD;
          xs = first_strip[1]; xt = first_tim[1]; ys = first_strip[0]; yt = first_tim[0];
        end
      end else if (!strip_ok(first_strip[1]) || !strip_ok(first_strip[0])) begin
        st = ST_UNCAL;
      end else if (cnt[1] == 1 && cnt[0] == 1) begin
        st = ST_SINGLE;
        xs = first_strip[1]; xt = first_tim[1]; ys = first_strip[0]; yt = first_tim[0];
      end else if (cnt[1] <= 2 && cnt[0] <= 2 &&
                   (cnt[1] == 1 || adj(1)) && (cnt[0] == 1 || adj(0))) begin
        st = ST_SHARED;
        xs = best_strip[1]; xt = best_tim[1]; ys = best_strip[0]; yt = best_tim[0];
      end
      if (st != ST_UNCAL && (!strip_ok(xs) || !strip_ok(ys))) st = ST_UNCAL;
      if (st != ST_UNCAL) begin
        e    = calib[(hit_det * STRIPS + (xs - 1)) * STRIPS + (ys - 1)];
        f    = longint'($signed(e[15:0]));
        b    = longint'($signed(e[31:16]));
        ff   = longint'($signed(e[47:32]));
        fb   = longint'($signed(e[63:48]));
        span = b - f;
        if (span == 0) begin
          st = ST_UNCAL;
        end else begin
          ctd = ((longint'(xt) - yt) * CTD_SCALE + longint'(dither)) * 16;
          z   = rdiv(SPAN_UM * (ctd - f), span) + FACE_UM;
          fw  = rdiv(SPAN_UM * (ff + fb), 2 * span);
          if (st != ST_LLD && (z < LOW_LIMIT_UM || z > HIGH_LIMIT_UM)) r.out_of_range = 1;
          // Depths just outside the faces are pulled onto the face.
          if (z < 0 && z > LOW_LIMIT_UM) z = 0;
          if (z > THICK_UM && z < HIGH_LIMIT_UM) z = THICK_UM;
          r.depth_front = 16'(sat(z, -32768, 32767));
          r.z_center    = 16'(sat(MID_UM - z, -32768, 32767));
          r.x_center    = 17'((longint'(ys) - CENTER_STRIP) * -PITCH_UM);
          r.y_center    = 17'((longint'(xs) - CENTER_STRIP) * -PITCH_UM);
          r.depth_fwhm  = 16'(sat(fw, 0, 65535));
        end
      end
      if (st == ST_UNCAL) r = '0;
      r.status       = st;
      r.hit_detector = 4'(hit_det);
      return r;
    endfunction

    function void check_word(logic [OUT_W-1:0] data);
      result_t got, want;
      got = data[$bits(result_t)-1:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.out_of_range != want.out_of_range) begin
        $display("%0t: out_of_range expected %0d actual %0d", $time,
                 want.out_of_range, got.out_of_range);
        errors++;
      end
      if (got.hit_detector != want.hit_detector) begin
        $display("%0t: hit_detector expected %0d actual %0d", $time,
                 want.hit_detector, got.hit_detector);
        errors++;
      end
      if (got.depth_front != want.depth_front) begin
        $display("%0t: depth_front expected %0d actual %0d", $time,
                 want.depth_front, got.depth_front);
        errors++;
      end
      if (got.z_center != want.z_center) begin
        $display("%0t: z_center expected %0d actual %0d", $time, want.z_center, got.z_center);
        errors++;
      end
      if (got.x_center != want.x_center) begin
        $display("%0t: x_center expected %0d actual %0d", $time, want.x_center, got.x_center);
        errors++;
      end
      if (got.y_center != want.y_center) begin
        $display("%0t: y_center expected %0d actual %0d", $time, want.y_center, got.y_center);
        errors++;
      end
      if (got.depth_fwhm != want.depth_fwhm) begin
        $display("%0t: depth_fwhm expected %0d actual %0d", $time,
                 want.depth_fwhm, got.depth_fwhm);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tlast = 0;
  logic             s_tuser = 0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  depth_scoreboard sb = new();
  int              words_sent = 0;
  bit              no_gaps = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  strip_detector_depth_calibration dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Master side: random back pressure, and every accepted word is checked.
  // Both m_tvalid and m_tready are read before this edge's updates land.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 0;
    end else if (no_gaps || $urandom_range(0, 99) < 70) begin
      m_tready <= 1;
    end else begin
      stall_left <= gap_len();
      m_tready   <= 0;
    end
  end

  // --------------------------------------------------------------------------
  // Slave side driver. The word is noted by the scoreboard at the edge that
  // accepts it; a following word sent without a gap keeps tvalid high without a dip.
  // --------------------------------------------------------------------------
  task automatic send_word(word_t w);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= w.kind;
    s_tlast  <= w.eoh;
    s_tdata  <= {1'b0, w.value, w.field, w.dither, w.energy, w.timing,
                 w.other, w.strip, w.x_side, w.det};
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
    words_sent++;
  endtask

  function automatic word_t blank_word();
    word_t w;
    w.kind = KIND_STRIP; w.det = '0; w.x_side = '0; w.strip = '0; w.other = '0;
    w.timing = '0; w.energy = '0; w.eoh = '0; w.dither = '0; w.field = '0; w.value = '0;
    return w;
  endfunction

  task automatic table_write(int det, int xs, int ys, logic [1:0] fld, logic [15:0] val);
    word_t w;
    w = blank_word();
    w.kind = KIND_WRITE; w.det = 4'(det); w.strip = 6'(xs); w.other = 6'(ys);
    w.field = fld; w.value = val;
    // The strip-only fields carry noise on a write; the block must ignore them.
    w.x_side = 1'($urandom); w.timing = 8'($urandom); w.energy = 16'($urandom);
    w.eoh = 1'($urandom); w.dither = 4'($urandom);
    send_word(w);
  endtask

  // Calibration values: a realistic spread around the CTD range, with the
  // occasional zero span, reversed span or full-scale value.
  function automatic logic [15:0] ctd_value(bit back);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    if (back) return 16'(5600 + $urandom_range(0, 1600) - 800);
    return 16'(-5600 + $urandom_range(0, 1600) - 800);
  endfunction

  function automatic logic [15:0] fwhm_value();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4000));
  endfunction

  task automatic write_pixel(int det, int xs, int ys);
    logic [15:0] f;
    f = ctd_value(0);
    table_write(det, xs, ys, FLD_FRONT_CTD, f);
    // Now and then the back equals the front so the span is zero.
    table_write(det, xs, ys, FLD_BACK_CTD, ($urandom_range(0, 19) == 0) ? f : ctd_value(1));
    table_write(det, xs, ys, FLD_FRONT_FWHM, fwhm_value());
    table_write(det, xs, ys, FLD_BACK_FWHM, fwhm_value());
  endtask

  function automatic int pick_strip();
    if ($urandom_range(0, 9) != 0) return win_strip[$urandom_range(0, 5)];
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(STRIPS + 1, 63);
  endfunction

  function automatic int pick_timing();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, TIMING_MAX);
    if (r < 92) return 0;
    return $urandom_range(TIMING_MAX + 1, 255);
  endfunction

  // One strip word of a hit, built from its fields.
  task automatic strip_word(int det, bit xside, int s, int t, int en, bit last,
                            logic signed [3:0] dith);
    word_t w;
    w = blank_word();
    w.det = 4'(det); w.x_side = xside; w.strip = 6'(s); w.timing = 8'(t);
    w.energy = 16'(en); w.eoh = last; w.dither = dith;
    w.other = 6'($urandom); w.field = 2'($urandom); w.value = 16'($urandom);
    send_word(w);
  endtask

  // A random hit: nx x strips and ny y strips, interleaved at random, with a
  // table write slipped in now and then while the hit is still open.
  task automatic random_hit(int nx, int ny);
    int det, n, rx, ry, en, s;
    bit xside;
    int xlist [$], ylist [$];
    det = ($urandom_range(0, 99) < 88) ? win_det[$urandom_range(0, 2)]
                                       : $urandom_range(DETECTORS, 15);
    for (int k = 0; k < 2; k++) begin
      int cnt_k;
      cnt_k = k ? nx : ny;
      if (cnt_k == 2 && $urandom_range(0, 99) < 65) begin
        s = 2 * $urandom_range(0, 2);
        if ($urandom_range(0, 1)) begin
          if (k) xlist = '{win_strip[s], win_strip[s+1]};
          else ylist = '{win_strip[s], win_strip[s+1]};
        end else begin
          if (k) xlist = '{win_strip[s+1], win_strip[s]};
          else ylist = '{win_strip[s+1], win_strip[s]};
        end
      end else begin
        for (int i = 0; i < cnt_k; i++)
          if (k) xlist = {xlist, pick_strip()}; else ylist = {ylist, pick_strip()};
      end
    end
    n = nx + ny; rx = nx; ry = ny; en = $urandom;
    for (int i = 0; i < n; i++) begin
      xside = (ry == 0) || (rx > 0 && $urandom_range(0, 1));
      if (xside) begin s = xlist.pop_front(); rx--; end
      else begin s = ylist.pop_front(); ry--; end
      // Repeat the previous energy sometimes so ties come up.
      if ($urandom_range(0, 9) != 0) en = $urandom;
      if (i < n - 1 && $urandom_range(0, 19) == 0)
        table_write(win_det[$urandom_range(0, 2)], win_strip[$urandom_range(0, 5)],
                    win_strip[$urandom_range(0, 5)], 2'($urandom), 16'($urandom));
      // Mostly one detector per hit, but the last strip decides.
      strip_word(($urandom_range(0, 19) == 0) ? win_det[$urandom_range(0, 2)] : det,
                 xside, s, pick_timing(), en, i == n - 1, 4'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int r;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Calibrate the pixel window on every chosen detector.
    foreach (win_det[d])
      foreach (win_strip[i])
        foreach (win_strip[j])
          write_pixel(win_det[d], win_strip[i], win_strip[j]);

    // Writes that must be ignored: detector or strip out of range.
    table_write(DETECTORS, 1, 1, FLD_FRONT_CTD, 16'h7fff);
    table_write(15, 37, 37, FLD_BACK_CTD, 16'h8000);
    table_write(0, 0, 1, FLD_FRONT_CTD, 16'h1234);
    table_write(0, 1, 63, FLD_BACK_FWHM, 16'hffff);

    // Directed: corner pixel with extreme table values.
    table_write(11, 37, 37, FLD_FRONT_CTD, 16'h8000);
    table_write(11, 37, 37, FLD_BACK_CTD, 16'h7fff);
    table_write(11, 37, 37, FLD_FRONT_FWHM, 16'h7fff);
    table_write(11, 37, 37, FLD_BACK_FWHM, 16'h7fff);
    // Single hits at timing extremes and dither extremes.
    strip_word(11, 1, 37, TIMING_MAX, 16'hffff, 0, 4'sd7);
    strip_word(11, 0, 37, 1, 0, 1, 4'sd7);
    strip_word(0, 1, 1, 1, 0, 0, -4'sd8);
    strip_word(0, 0, 1, TIMING_MAX, 16'hffff, 1, -4'sd8);
    // LLD single: x timing zero, then a y timing above the valid range.
    strip_word(5, 1, 19, 0, 100, 0, 0);
    strip_word(5, 0, 20, 1, 100, 1, 0);
    strip_word(5, 0, 2, 255, 7, 0, 0);
    strip_word(5, 1, 1, 20, 7, 1, 3);
    // LLD on a multi-strip hit, and a missing side.
    strip_word(0, 1, 19, 0, 5, 0, 0);
    strip_word(0, 1, 20, 0, 5, 0, 0);
    strip_word(0, 0, 19, 10, 5, 1, 0);
    strip_word(0, 1, 2, 10, 5, 1, 0);
    // Shared two-by-two with an energy tie, and a non-adjacent pair.
    strip_word(11, 1, 36, 10, 500, 0, 1);
    strip_word(11, 0, 1, 12, 500, 0, 1);
    strip_word(11, 1, 37, 11, 500, 0, 1);
    strip_word(11, 0, 2, 13, 900, 1, 1);
    strip_word(5, 1, 1, 10, 5, 0, 0);
    strip_word(5, 1, 19, 10, 9, 0, 0);
    strip_word(5, 0, 1, 10, 5, 1, 0);
    // Bad detector and a strip out of range.
    strip_word(15, 1, 1, 10, 5, 0, 0);
    strip_word(15, 0, 1, 10, 5, 1, 0);
    strip_word(0, 1, 63, 10, 5, 0, 0);
    strip_word(0, 0, 1, 10, 5, 1, 0);

    // Random part, in stretches with and without idling.
    while (words_sent < 1800) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (20) begin
        r = $urandom_range(0, 99);
        if (r < 35) random_hit(1, 1);
        else if (r < 47) random_hit(1, 2);
        else if (r < 59) random_hit(2, 1);
        else if (r < 72) random_hit(2, 2);
        else if (r < 78) random_hit(0, $urandom_range(1, 3));
        else if (r < 82) random_hit($urandom_range(1, 3), 0);
        else if (r < 88) random_hit($urandom_range(3, 6), $urandom_range(5, 6));
        else if (r < 92) write_pixel(win_det[$urandom_range(0, 2)],
                                     win_strip[$urandom_range(0, 5)],
                                     win_strip[$urandom_range(0, 5)]);
        else random_hit($urandom_range(1, 3), $urandom_range(1, 3));
      end
    end
    s_tvalid <= 0;
    no_gaps = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

endmodule
